// ===== rtl/core/bpsd_pkg.sv =====
// Shared types and constants for the BMP pixel stream decoder.
package bpsd_pkg;

    // One input item: a file byte and the new-file marker
    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_flag;
    } t_byte_item;

    // One result item: a pixel or an error report
    typedef struct packed {
        logic [11:0] pixel_x;
        logic [11:0] pixel_y;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [1:0]  status;
        logic        last;
    } t_result;

    // Parser phases
    typedef enum logic [1:0] {
        PH_HEADER,
        PH_SKIP,
        PH_PIXELS,
        PH_DONE
    } t_phase;

    // Result status codes
    localparam logic [1:0] ST_PIXEL      = 2'd0;
    localparam logic [1:0] ST_DEPTH      = 2'd1;
    localparam logic [1:0] ST_COMPRESSED = 2'd2;
    localparam logic [1:0] ST_RANGE      = 2'd3;

    // Header layout (byte offsets, little-endian fields)
    localparam logic [31:0] HDR_BYTES   = 32'd54;
    localparam logic [31:0] HDR_LAST    = 32'd53;
    localparam logic [31:0] OFS_OFFSET  = 32'd10;
    localparam logic [31:0] OFS_WIDTH   = 32'd18;
    localparam logic [31:0] OFS_HEIGHT  = 32'd22;
    localparam logic [31:0] OFS_BITS    = 32'd28;
    localparam logic [31:0] OFS_COMP    = 32'd30;

    // Supported bit counts
    localparam logic [15:0] BITS_24 = 16'd24;
    localparam logic [15:0] BITS_32 = 16'd32;

    // Result queue geometry
    localparam int unsigned      QUEUE_DEPTH = 4;
    localparam int unsigned      QPTR_W      = 2;
    localparam int unsigned      QCNT_W      = 3;
    localparam logic [QCNT_W-1:0] QUEUE_FULL = 3'd4;

endpackage

// ===== rtl/core/bpsd_front.sv =====
// Front end: header capture, validation, and pixel assembly, one byte per cycle while i_accept is high.
module bpsd_front import bpsd_pkg::*; #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  t_byte_item i_item,
    output logic       o_push,
    output t_result    o_result
);

    localparam int WW   = $clog2(MAX_WIDTH + 1);
    localparam int HW   = $clog2(MAX_HEIGHT + 1);
    localparam int PADW = WW + 2;

    localparam logic [1:0] BIP_BLUE  = 2'd0;
    localparam logic [1:0] BIP_GREEN = 2'd1;
    localparam logic [1:0] BIP_RED   = 2'd2;
    localparam logic [1:0] BIP_SPARE = 2'd3;

    t_phase          r_phase, n_phase, c_phase;
    logic [31:0]     r_pos, n_pos, c_pos;
    logic [31:0]     r_offset, n_offset;
    logic [31:0]     r_raw_w, n_raw_w;
    logic [31:0]     r_raw_h, n_raw_h;
    logic [15:0]     r_raw_bits, n_raw_bits;
    logic            r_comp_nz, n_comp_nz;
    logic [WW-1:0]   r_width, n_width, r_col, n_col, col_inc;
    logic [HW-1:0]   r_height, n_height, r_row, n_row, row_inc, y_pos;
    logic            r_top, n_top, r_wide, n_wide;
    logic [1:0]      r_bip, n_bip, r_pad, n_pad;
    logic [7:0]      r_blue, n_blue, r_green, n_green;
    logic [1:0]      hdr_err;
    logic [31:0]     h_mag;
    logic            range_bad, bits_ok;
    logic            hdr_last, skip_done, pix_go, pix_fin;
    logic [1:0]      lane_off, lane_w, lane_h, lane_b, lane_c;
    logic [PADW-1:0] w_ext;
    logic [7:0]      byte_in;

    // A start flag restarts the parser on this very byte
    assign byte_in = i_item.data_byte;
    assign c_phase = i_item.start_flag ? PH_HEADER : r_phase;
    assign c_pos   = i_item.start_flag ? '0 : r_pos;

    assign hdr_last  = (c_pos == HDR_LAST);
    assign skip_done = (c_pos >= r_offset);
    assign pix_go    = (c_phase == PH_PIXELS) || ((c_phase == PH_SKIP) && skip_done);

    assign lane_off = 2'(c_pos - OFS_OFFSET);
    assign lane_w   = 2'(c_pos - OFS_WIDTH);
    assign lane_h   = 2'(c_pos - OFS_HEIGHT);
    assign lane_b   = 2'(c_pos - OFS_BITS);
    assign lane_c   = 2'(c_pos - OFS_COMP);

    // Header validation, depth first, then compression, then range
    assign bits_ok   = (r_raw_bits == BITS_24) || (r_raw_bits == BITS_32);
    assign h_mag     = r_raw_h[31] ? (32'd0 - r_raw_h) : r_raw_h;
    assign range_bad = r_raw_w[31] || (r_raw_w == 32'd0) || (r_raw_w > 32'(MAX_WIDTH))
                    || (h_mag == 32'd0) || (h_mag > 32'(MAX_HEIGHT))
                    || (r_offset < HDR_BYTES);

    always_comb begin
        priority if (!bits_ok) begin
            hdr_err = ST_DEPTH;
        end else if (r_comp_nz) begin
            hdr_err = ST_COMPRESSED;
        end else if (range_bad) begin
            hdr_err = ST_RANGE;
        end else begin
            hdr_err = ST_PIXEL;
        end
    end

    // Pixel position helpers
    assign col_inc = r_col + 1'b1;
    assign row_inc = r_row + 1'b1;
    assign y_pos   = r_top ? r_row : (r_height - 1'b1 - r_row);
    assign w_ext   = PADW'(r_width);
    assign pix_fin = pix_go && (r_pad == 2'd0) && (r_bip == BIP_RED)
                  && (col_inc == r_width) && (row_inc == r_height);

    // Next phase
    always_comb begin
        n_phase = r_phase;
        if (i_accept) begin
            n_phase = c_phase;
            unique case (c_phase)
                PH_HEADER: begin
                    if (hdr_last) begin
                        n_phase = (hdr_err != ST_PIXEL) ? PH_DONE : PH_SKIP;
                    end
                end
                PH_SKIP: begin
                    if (skip_done) begin
                        n_phase = PH_PIXELS;
                    end
                end
                PH_PIXELS: ;
                PH_DONE:   ;
            endcase
            if (pix_fin) begin
                n_phase = PH_DONE;
            end
        end
    end

    // Datapath and result
    always_comb begin
        n_pos      = r_pos;
        n_offset   = r_offset;
        n_raw_w    = r_raw_w;
        n_raw_h    = r_raw_h;
        n_raw_bits = r_raw_bits;
        n_comp_nz  = r_comp_nz;
        n_width    = r_width;
        n_height   = r_height;
        n_col      = r_col;
        n_row      = r_row;
        n_top      = r_top;
        n_wide     = r_wide;
        n_bip      = r_bip;
        n_pad      = r_pad;
        n_blue     = r_blue;
        n_green    = r_green;
        o_push     = 1'b0;
        o_result   = '0;

        if (i_accept) begin
            // saturating byte counter
            n_pos = (c_pos == 32'hFFFF_FFFF) ? c_pos : c_pos + 32'd1;

            if (c_phase == PH_HEADER) begin
                // field capture
                if (c_pos >= OFS_OFFSET && c_pos < OFS_OFFSET + 32'd4) begin
                    n_offset[8*lane_off +: 8] = byte_in;
                end
                if (c_pos >= OFS_WIDTH && c_pos < OFS_WIDTH + 32'd4) begin
                    n_raw_w[8*lane_w +: 8] = byte_in;
                end
                if (c_pos >= OFS_HEIGHT && c_pos < OFS_HEIGHT + 32'd4) begin
                    n_raw_h[8*lane_h +: 8] = byte_in;
                end
                if (c_pos >= OFS_BITS && c_pos < OFS_BITS + 32'd2) begin
                    n_raw_bits[8*lane_b[0] +: 8] = byte_in;
                end
                if (c_pos >= OFS_COMP && c_pos < OFS_COMP + 32'd4) begin
                    n_comp_nz = ((lane_c != 2'd0) && r_comp_nz) || (byte_in != 8'd0);
                end

                // end of header: report or set up the image
                if (hdr_last) begin
                    if (hdr_err != ST_PIXEL) begin
                        o_push          = 1'b1;
                        o_result.status = hdr_err;
                        o_result.last   = 1'b1;
                    end else begin
                        n_width  = r_raw_w[WW-1:0];
                        n_height = h_mag[HW-1:0];
                        n_top    = r_raw_h[31];
                        n_wide   = (r_raw_bits == BITS_32);
                        n_col    = '0;
                        n_row    = '0;
                        n_bip    = BIP_BLUE;
                        n_pad    = 2'd0;
                    end
                end
            end

            if (pix_go) begin
                priority if (r_pad != 2'd0) begin
                    n_pad = r_pad - 2'd1;
                end else begin
                    unique case (r_bip)
                        BIP_BLUE: begin
                            n_blue = byte_in;
                            n_bip  = BIP_GREEN;
                        end
                        BIP_GREEN: begin
                            n_green = byte_in;
                            n_bip   = BIP_RED;
                        end
                        BIP_RED: begin
                            o_push           = 1'b1;
                            o_result.pixel_x = 12'(r_col);
                            o_result.pixel_y = 12'(y_pos);
                            o_result.red     = byte_in;
                            o_result.green   = r_green;
                            o_result.blue    = r_blue;
                            o_result.status  = ST_PIXEL;
                            o_result.last    = pix_fin;
                            if (!pix_fin) begin
                                if (r_wide) begin
                                    n_bip = BIP_SPARE;
                                end else begin
                                    n_bip = BIP_BLUE;
                                    if (col_inc >= r_width) begin
                                        n_col = '0;
                                        n_row = row_inc;
                                        n_pad = w_ext[1:0];
                                    end else begin
                                        n_col = col_inc;
                                    end
                                end
                            end
                        end
                        BIP_SPARE: begin
                            // fourth byte of a 32-bit pixel: dropped, no row padding
                            n_bip = BIP_BLUE;
                            if (col_inc >= r_width) begin
                                n_col = '0;
                                n_row = row_inc;
                                n_pad = 2'd0;
                            end else begin
                                n_col = col_inc;
                            end
                        end
                    endcase
                end
            end
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
            r_pos   <= '0;
            r_wide  <= 1'b0;
            r_pad   <= 2'd0;
            r_bip   <= BIP_BLUE;
        end else begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_wide  <= n_wide;
            r_pad   <= n_pad;
            r_bip   <= n_bip;
        end
    end

    // Header fields and pixel payload
    always_ff @(posedge i_clk) begin
        r_offset   <= n_offset;
        r_raw_w    <= n_raw_w;
        r_raw_h    <= n_raw_h;
        r_raw_bits <= n_raw_bits;
        r_comp_nz  <= n_comp_nz;
        r_width    <= n_width;
        r_height   <= n_height;
        r_col      <= n_col;
        r_row      <= n_row;
        r_top      <= n_top;
        r_blue     <= n_blue;
        r_green    <= n_green;
    end

    // Every error report closes its file
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push && (o_result.status != ST_PIXEL) |-> o_result.last)
        else $error("error result without last");

    // After the closing result the parser ignores bytes
    a_last_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push && o_result.last |=> (r_phase == PH_DONE))
        else $error("parser not done after last result");

    // 32-bit pixels never carry row padding
    a_wide_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wide |-> (r_pad == 2'd0))
        else $error("padding pending on 32-bit image");

endmodule

// ===== rtl/core/bpsd_queue.sv =====
// Back end: short result queue that drives the output channel.
module bpsd_queue import bpsd_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_result,
    output logic    o_full,
    output logic    o_valid,
    input  logic    i_stall,
    output t_result o_result
);

    t_result             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr, n_wr, r_rd, n_rd;
    logic [QCNT_W-1:0]   r_cnt, n_cnt;
    logic                pop;

    assign o_full   = (r_cnt == QUEUE_FULL);
    assign o_valid  = (r_cnt != '0);
    assign o_result = r_mem[r_rd];
    assign pop      = o_valid && !i_stall;

    // Pointer and count update
    always_comb begin
        n_wr  = i_push ? r_wr + 1'b1 : r_wr;
        n_rd  = pop ? r_rd + 1'b1 : r_rd;
        n_cnt = r_cnt + QCNT_W'(i_push) - QCNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_result;
        end
    end

    // Count never passes the depth
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= QUEUE_FULL)
        else $error("queue count out of range");

    // Front end holds off while the queue is full
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("push into full queue");

    // A stalled result item stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_result))
        else $error("stalled result changed");

endmodule

// ===== rtl/core/bmp_pixel_stream_decoder.sv =====
// Top level of the BMP pixel stream decoder.
// Takes a BMP file one byte per cycle while o_stall is low and returns one item per pixel
// (x, y with row 0 at the top, red, green, blue) or a single error item; start_flag on a
// byte restarts parsing with that byte as header byte 0. Only uncompressed 24- and 32-bit
// files are decoded: other depths, compression, a width outside 1..MAX_WIDTH, a height
// magnitude outside 1..MAX_HEIGHT or a pixel offset inside the 54-byte header give one
// error item with last set. Each accepted byte is handled as it arrives, so the input
// accepts one item per clock while o_stall is low; the byte that completes a result pushes
// it into the result queue. The output side is decoupled by that four-entry queue, and
// o_stall rises only when it is full. After the last pixel or an error, bytes are taken
// and ignored until the next start flag.
module bmp_pixel_stream_decoder import bpsd_pkg::*; #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  t_byte_item i_item,
    output logic       o_valid,
    input  logic       i_stall,
    output t_result    o_result
);

    logic    accept;
    logic    push;
    logic    full;
    t_result front_result;

    // Input item taken whenever the queue has room
    assign o_stall = full;
    assign accept  = i_valid && !full;

    bpsd_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (i_item),
        .o_push   (push),
        .o_result (front_result)
    );

    bpsd_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_result (front_result),
        .o_full   (full),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_result (o_result)
    );

endmodule
